>>> hw/rtl/hacc_pkg.sv
// Shared types and constants for the histogram accumulator.
// Used by the controller, the datapath and the top level; no dependencies.
package hacc_pkg;

    // Default number of bin index bits (2^12 bins).
    localparam int DEF_BIN_BITS = 12;

    // Fixed field widths of the request and result items.
    localparam int REQ_W      = 2;
    localparam int BIN_W      = 16;
    localparam int CNT_W      = 32;
    localparam int PEAK_BIN_W = 12;

    // Request codes. The unused code behaves as a read.
    localparam logic [REQ_W-1:0] REQ_FILL  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RESP,
        ST_MODIFY,
        ST_CLEAR
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clr_step;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic new_clear;
        logic new_in_range;
        logic clr_last;
    } t_dp_sts;

endpackage

>>> hw/rtl/hacc_ctrl.sv
// Controller state machine of the histogram accumulator.
// Depends on hacc_pkg for the state type and the command and status structs.
module hacc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  hacc_pkg::t_dp_sts i_sts,
    output hacc_pkg::t_dp_cmd o_cmd,
    output logic              busy
);
    import hacc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_sts.new_clear) begin
                        n_state = ST_CLEAR;
                    end else if (i_sts.new_in_range) begin
                        n_state = ST_MODIFY;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_RESP:   n_state = ST_IDLE;
            ST_MODIFY: n_state = ST_IDLE;
            ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        case (r_state)
            ST_INIT: begin
                o_cmd.clr_step = 1'b1;
            end
            ST_IDLE: begin
                busy         = 1'b0;
                o_cmd.accept = start;
            end
            ST_RESP: begin
                o_cmd.finish = 1'b1;
            end
            ST_MODIFY: begin
                o_cmd.finish = 1'b1;
            end
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.finish   = i_sts.clr_last;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

>>> hw/rtl/hacc_dp.sv
// Datapath of the histogram accumulator: bin memory, total, peak and result registers.
// Depends on hacc_pkg for field widths, request codes and the command and status structs.
module hacc_dp #(
    parameter int BIN_BITS = hacc_pkg::DEF_BIN_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  hacc_pkg::t_dp_cmd                 i_cmd,
    output hacc_pkg::t_dp_sts                 o_sts,
    input  logic [hacc_pkg::REQ_W-1:0]        i_req_type,
    input  logic [hacc_pkg::BIN_W-1:0]        i_bin,
    input  logic [hacc_pkg::CNT_W-1:0]        i_weight,
    output logic                              o_valid,
    output logic [hacc_pkg::CNT_W-1:0]        o_bin_count,
    output logic                              o_in_range,
    output logic [hacc_pkg::CNT_W-1:0]        o_total_count,
    output logic [hacc_pkg::CNT_W-1:0]        o_peak_value,
    output logic [hacc_pkg::PEAK_BIN_W-1:0]   o_peak_bin
);
    import hacc_pkg::*;

    localparam int NUM_BINS = 1 << BIN_BITS;

    logic [CNT_W-1:0]    mem [NUM_BINS];

    logic [REQ_W-1:0]    r_req;
    logic [BIN_BITS-1:0] r_bin;
    logic [CNT_W-1:0]    r_weight;
    logic                r_in_range;
    logic [CNT_W-1:0]    r_rdata;
    logic [BIN_BITS-1:0] r_clr_addr;
    logic [CNT_W-1:0]    r_total;
    logic [CNT_W-1:0]    r_peak;
    logic [BIN_BITS-1:0] r_peak_idx;

    logic                new_in_range;
    logic                is_fill;
    logic [CNT_W:0]      bin_sum;
    logic [CNT_W-1:0]    bin_new;
    logic [CNT_W:0]      tot_sum;
    logic [CNT_W-1:0]    tot_new;
    logic                peak_hit;
    logic [CNT_W-1:0]    res_count;

    assign new_in_range = ((32'(i_bin) >> BIN_BITS) == 32'd0);

    assign o_sts.new_clear    = (i_req_type == REQ_CLEAR);
    assign o_sts.new_in_range = new_in_range;
    assign o_sts.clr_last     = (r_clr_addr == {BIN_BITS{1'b1}});

    // Saturating adds for the addressed bin and the running total.
    assign is_fill  = (r_req == REQ_FILL);
    assign bin_sum  = {1'b0, r_rdata} + {1'b0, r_weight};
    assign bin_new  = bin_sum[CNT_W] ? {CNT_W{1'b1}} : bin_sum[CNT_W-1:0];
    assign tot_sum  = {1'b0, r_total} + {1'b0, r_weight};
    assign tot_new  = tot_sum[CNT_W] ? {CNT_W{1'b1}} : tot_sum[CNT_W-1:0];
    assign peak_hit = (bin_new >= r_peak);

    always_comb begin
        if (r_req == REQ_CLEAR || !r_in_range) begin
            res_count = '0;
        end else if (is_fill) begin
            res_count = bin_new;
        end else begin
            res_count = r_rdata;
        end
    end

    // Bin memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_clr_addr] <= '0;
        end else if (i_cmd.finish && is_fill && r_in_range) begin
            mem[r_bin] <= bin_new;
        end
        r_rdata <= mem[i_bin[BIN_BITS-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req      <= i_req_type;
            r_bin      <= i_bin[BIN_BITS-1:0];
            r_weight   <= i_weight;
            r_in_range <= new_in_range;
        end
        if (i_cmd.finish) begin
            o_bin_count <= res_count;
            o_in_range  <= r_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_total    <= '0;
            r_peak     <= '0;
            r_peak_idx <= '0;
            o_valid    <= 1'b0;
        end else begin
            o_valid <= i_cmd.finish;
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + BIN_BITS'(1);
            end
            if (i_cmd.finish) begin
                if (r_req == REQ_CLEAR) begin
                    r_total    <= '0;
                    r_peak     <= '0;
                    r_peak_idx <= '0;
                end else if (is_fill && r_in_range) begin
                    r_total <= tot_new;
                    if (peak_hit) begin
                        r_peak     <= bin_new;
                        r_peak_idx <= r_bin;
                    end
                end
            end
        end
    end

    // Totals shown with a result are the values after the request.
    assign o_total_count = r_total;
    assign o_peak_value  = r_peak;
    assign o_peak_bin    = PEAK_BIN_W'(r_peak_idx);

endmodule

>>> hw/rtl/histogram_accumulator.sv
// Top level of the weighted histogram accumulator with peak tracking.
// Depends on hacc_pkg, hacc_ctrl and hacc_dp.

// A request is taken at a rising edge where start is high and busy is low, and
// gives exactly one result, shown for one cycle with o_valid high; the receiver
// cannot hold it off. A fill or read holds busy high until its result is
// registered, so no new request is taken before that. The bin is read through the
// registered read port of the bin memory as the request is taken; the weight is
// then added, written back and the result registered. An out-of-range request
// also holds busy until its result is registered. A clear walks the bin memory one
// bin per cycle. After reset the same walk runs once without a result, and busy
// stays high until it is done, so no request is taken before. total, peak value
// and peak bin on the result ports always reflect the state after the request;
// they stay stable between results and are valid to sample while o_valid is high.
module histogram_accumulator #(
    parameter int BIN_BITS = hacc_pkg::DEF_BIN_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [hacc_pkg::REQ_W-1:0]       i_req_type,
    input  logic [hacc_pkg::BIN_W-1:0]       i_bin,
    input  logic [hacc_pkg::CNT_W-1:0]       i_weight,
    output logic                             o_valid,
    output logic [hacc_pkg::CNT_W-1:0]       o_bin_count,
    output logic                             o_in_range,
    output logic [hacc_pkg::CNT_W-1:0]       o_total_count,
    output logic [hacc_pkg::CNT_W-1:0]       o_peak_value,
    output logic [hacc_pkg::PEAK_BIN_W-1:0]  o_peak_bin
);
    import hacc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // The controller sequences accept, read-modify-write and the clear walk.
    hacc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // The datapath owns the bin memory, the total, the peak and the result registers.
    hacc_dp #(
        .BIN_BITS (BIN_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_req_type    (i_req_type),
        .i_bin         (i_bin),
        .i_weight      (i_weight),
        .o_valid       (o_valid),
        .o_bin_count   (o_bin_count),
        .o_in_range    (o_in_range),
        .o_total_count (o_total_count),
        .o_peak_value  (o_peak_value),
        .o_peak_bin    (o_peak_bin)
    );

endmodule

>>> hw/rtl/histogram_accumulator_checker.sv
// Port-level checks for the histogram accumulator, attached by a bind statement.
// Depends on hacc_pkg for field widths and on histogram_accumulator.
module hacc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_valid,
    input logic [hacc_pkg::CNT_W-1:0]       o_bin_count,
    input logic                             o_in_range,
    input logic [hacc_pkg::CNT_W-1:0]       o_peak_value
);

    // Every accepted item raises busy in the cycle after it is taken.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // A result never shows up in two consecutive cycles.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // A result always closes a busy period.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a preceding busy cycle");

    // Out-of-range requests report a zero count.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_in_range) |-> (o_bin_count == '0))
        else $error("out-of-range result with nonzero count");

    // No bin can exceed the tracked peak.
    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_peak_value >= o_bin_count))
        else $error("bin count above peak value");

endmodule

bind histogram_accumulator hacc_checker u_hacc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_bin_count  (o_bin_count),
    .o_in_range   (o_in_range),
    .o_peak_value (o_peak_value)
);
